[rtl/core/arpc_pkg.sv]
// ----------------------------------------------------------------------------
// arpc_pkg: shared types and constants for the ARP responder and cache
// Holds the transfer payload structs, the table entry and memory port
// structs, the sequencer states and the ARP field constants.
// ----------------------------------------------------------------------------
package arpc_pkg;

  // Cache geometry. The index and count widths follow from the depth.
  localparam int CACHE_ENTRIES = 128;
  localparam int IDX_W         = $clog2(CACHE_ENTRIES);
  localparam int CNT_W         = $clog2(CACHE_ENTRIES + 1);

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 48;

  // ARP header values accepted for IPv4 over Ethernet.
  localparam logic [10:0] MIN_LEN     = 11'd28;
  localparam logic [15:0] HW_ETHERNET = 16'h0001;
  localparam logic [15:0] PROTO_IPV4  = 16'h0800;
  localparam logic [7:0]  HW_SIZE     = 8'd6;
  localparam logic [7:0]  PROTO_SIZE  = 8'd4;
  localparam logic [15:0] OP_REQUEST  = 16'd1;
  localparam logic [15:0] OP_REPLY    = 16'd2;
  localparam logic [47:0] BCAST_MAC   = 48'hFFFF_FFFF_FFFF;

  // Item modes.
  localparam logic MODE_MESSAGE = 1'b0;
  localparam logic MODE_LOOKUP  = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_IP  = 1'b0,
    CFG_OWN_MAC = 1'b1
  } arpc_cfg_idx_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } arpc_state_t;

  // What an accepted item asks for.
  typedef enum logic [1:0] {
    KIND_LOOKUP,
    KIND_REQUEST,
    KIND_REPLY,
    KIND_REJECT
  } arpc_kind_t;

  // Input item.
  typedef struct packed {
    logic        mode;
    logic [10:0] payload_length;
    logic [15:0] hardware_type;
    logic [15:0] protocol_type;
    logic [7:0]  hw_addr_size;
    logic [7:0]  proto_addr_size;
    logic [15:0] opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic [31:0] query_ip;
  } arpc_in_t;

  // Result item.
  typedef struct packed {
    logic        send_reply;
    logic [47:0] reply_dst_mac;
    logic [31:0] reply_dst_ip;
    logic        lookup_hit;
    logic [47:0] lookup_mac;
    logic        need_request;
    logic        table_full_drop;
  } arpc_out_t;

  // One cache entry as held in the table memory.
  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
  } arpc_entry_t;

  // Table memory access from the sequencer.
  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    arpc_entry_t      wdata;
  } arpc_ram_req_t;

endpackage

[rtl/core/arp_responder_and_cache.sv]
// A rejected message goes straight to forming its result; a lookup or an accepted message
// first searches the table linearly, one entry per cycle, and stops at the first entry
// that matches or after the last valid entry.
// A new item is taken only once the previous result has been loaded into the result
// register, so the block does not overlap items.
// Reset clears the entry count, own_ip and the result valid flag; the table is not cleared.
// ----------------------------------------------------------------------------
// arp_responder_and_cache: ARP responder with IPv4-to-MAC cache
// Holds the configuration registers and the result register, and joins the
// search sequencer to the table memory.
// ----------------------------------------------------------------------------
module arp_responder_and_cache (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  arpc_pkg::arpc_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output arpc_pkg::arpc_out_t             out_data,
  input  logic                            cfg_we,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arpc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [31:0]             own_ip_r;
  logic                    out_valid_r, out_valid_nxt;
  arpc_pkg::arpc_out_t     out_data_r;
  logic                    out_free;
  logic                    res_load;
  arpc_pkg::arpc_out_t     res;
  arpc_pkg::arpc_ram_req_t ram_req;
  arpc_pkg::arpc_entry_t   ram_rdata;

  // Configuration writes. own_mac only sources the MAC of transmitted
  // replies, which is added by the transmit path, so it is not held here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r <= '0;
    end else if (cfg_we) begin
      case (arpc_pkg::arpc_cfg_idx_t'(cfg_index))
        arpc_pkg::CFG_OWN_IP: begin
          own_ip_r <= cfg_wdata[31:0];
        end
        default: begin
          // Own MAC: no state in this block.
        end
      endcase
    end
  end

  // Result register: free when empty or when its transfer completes.
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  arpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .own_ip    (own_ip_r),
    .out_free  (out_free),
    .res_load  (res_load),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  arpc_table_ram u_table (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

endmodule

[rtl/core/arpc_table_ram.sv]
// ----------------------------------------------------------------------------
// arpc_table_ram: IP-to-MAC table storage
// Single-port-write, single-port-read synchronous memory with a registered
// read port. Contents are undefined until written.
// ----------------------------------------------------------------------------
module arpc_table_ram (
  input  logic                   clk,
  input  arpc_pkg::arpc_ram_req_t req,
  output arpc_pkg::arpc_entry_t   rdata
);

  arpc_pkg::arpc_entry_t mem [arpc_pkg::CACHE_ENTRIES];
  arpc_pkg::arpc_entry_t rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/arpc_ctrl.sv]
// ----------------------------------------------------------------------------
// arpc_ctrl: message checking and table search sequencer
// Checks each accepted item, walks the valid part of the table one entry
// per cycle with the memory read pipelined against the compare, then for an
// accepted message updates or appends the entry, and forms the result.
// ----------------------------------------------------------------------------
module arpc_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  arpc_pkg::arpc_in_t      in_data,
  input  logic [31:0]             own_ip,
  input  logic                    out_free,
  output logic                    res_load,
  output arpc_pkg::arpc_out_t     res,
  output arpc_pkg::arpc_ram_req_t ram_req,
  input  arpc_pkg::arpc_entry_t   ram_rdata
);

  arpc_pkg::arpc_state_t             state_r, state_nxt;
  arpc_pkg::arpc_kind_t              kind_r, kind_nxt;
  logic [31:0]                       key_ip_r, key_ip_nxt;
  logic [47:0]                       smac_r, smac_nxt;
  logic [arpc_pkg::CNT_W-1:0]        rd_idx_r, rd_idx_nxt;
  logic                              pend_r, pend_nxt;
  logic [arpc_pkg::IDX_W-1:0]        cmp_idx_r, cmp_idx_nxt;
  logic                              hit_r, hit_nxt;
  logic [arpc_pkg::IDX_W-1:0]        hit_idx_r, hit_idx_nxt;
  logic [47:0]                       hit_mac_r, hit_mac_nxt;
  logic [arpc_pkg::CNT_W-1:0]        count_r, count_nxt;

  logic                              msg_ok;
  arpc_pkg::arpc_kind_t              in_kind;
  logic                              match;
  logic                              issue;
  logic                              full;

  // Header checks and classification of the offered item.
  always_comb begin
    msg_ok = (in_data.payload_length >= arpc_pkg::MIN_LEN) &&
             (in_data.hardware_type == arpc_pkg::HW_ETHERNET) &&
             (in_data.protocol_type == arpc_pkg::PROTO_IPV4) &&
             (in_data.hw_addr_size == arpc_pkg::HW_SIZE) &&
             (in_data.proto_addr_size == arpc_pkg::PROTO_SIZE) &&
             (in_data.target_ip == own_ip);
    if (in_data.mode == arpc_pkg::MODE_LOOKUP) begin
      in_kind = arpc_pkg::KIND_LOOKUP;
    end else if (msg_ok && in_data.opcode == arpc_pkg::OP_REQUEST) begin
      in_kind = arpc_pkg::KIND_REQUEST;
    end else if (msg_ok && in_data.opcode == arpc_pkg::OP_REPLY) begin
      in_kind = arpc_pkg::KIND_REPLY;
    end else begin
      in_kind = arpc_pkg::KIND_REJECT;
    end
  end

  assign match = pend_r && (ram_rdata.ip == key_ip_r);
  assign issue = rd_idx_r < count_r;
  assign full  = count_r == arpc_pkg::CNT_W'(arpc_pkg::CACHE_ENTRIES);

  // State register and control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= arpc_pkg::ST_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Item and search registers.
  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    key_ip_r  <= key_ip_nxt;
    smac_r    <= smac_nxt;
    rd_idx_r  <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    hit_r     <= hit_nxt;
    hit_idx_r <= hit_idx_nxt;
    hit_mac_r <= hit_mac_nxt;
  end

  // Next state, memory accesses and result.
  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    key_ip_nxt  = key_ip_r;
    smac_nxt    = smac_r;
    rd_idx_nxt  = rd_idx_r;
    pend_nxt    = pend_r;
    cmp_idx_nxt = cmp_idx_r;
    hit_nxt     = hit_r;
    hit_idx_nxt = hit_idx_r;
    hit_mac_nxt = hit_mac_r;
    count_nxt   = count_r;
    in_ready    = 1'b0;
    res_load    = 1'b0;
    res         = '0;
    ram_req     = '0;

    case (state_r)
      arpc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          kind_nxt   = in_kind;
          key_ip_nxt = (in_data.mode == arpc_pkg::MODE_LOOKUP) ?
                       in_data.query_ip : in_data.sender_ip;
          smac_nxt   = in_data.sender_mac;
          rd_idx_nxt = '0;
          pend_nxt   = 1'b0;
          hit_nxt    = 1'b0;
          state_nxt  = (in_kind == arpc_pkg::KIND_REJECT) ?
                       arpc_pkg::ST_FINISH : arpc_pkg::ST_SCAN;
        end
      end

      // One read issued per cycle; the compare sees the previous read.
      arpc_pkg::ST_SCAN: begin
        if (match) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = cmp_idx_r;
          hit_mac_nxt = ram_rdata.mac;
          pend_nxt    = 1'b0;
          state_nxt   = arpc_pkg::ST_FINISH;
        end else if (issue) begin
          ram_req.re  = 1'b1;
          ram_req.raddr = rd_idx_r[arpc_pkg::IDX_W-1:0];
          cmp_idx_nxt = rd_idx_r[arpc_pkg::IDX_W-1:0];
          pend_nxt    = 1'b1;
          rd_idx_nxt  = rd_idx_r + arpc_pkg::CNT_W'(1);
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = arpc_pkg::ST_FINISH;
        end
      end

      // Form the result; the table is written as the result is handed over.
      arpc_pkg::ST_FINISH: begin
        ram_req.wdata.ip  = key_ip_r;
        ram_req.wdata.mac = smac_r;
        case (kind_r)
          arpc_pkg::KIND_LOOKUP: begin
            if (hit_r) begin
              res.lookup_hit = 1'b1;
              res.lookup_mac = hit_mac_r;
            end else begin
              res.lookup_mac   = arpc_pkg::BCAST_MAC;
              res.need_request = 1'b1;
            end
          end
          arpc_pkg::KIND_REQUEST, arpc_pkg::KIND_REPLY: begin
            if (kind_r == arpc_pkg::KIND_REQUEST) begin
              res.send_reply    = 1'b1;
              res.reply_dst_mac = smac_r;
              res.reply_dst_ip  = key_ip_r;
            end
            if (hit_r) begin
              ram_req.we    = out_free;
              ram_req.waddr = hit_idx_r;
            end else if (!full) begin
              ram_req.we    = out_free;
              ram_req.waddr = count_r[arpc_pkg::IDX_W-1:0];
              if (out_free) begin
                count_nxt = count_r + arpc_pkg::CNT_W'(1);
              end
            end else begin
              res.table_full_drop = 1'b1;
            end
          end
          default: begin
            // Rejected message: all-zero result, table untouched.
          end
        endcase
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = arpc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = arpc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/arpc_checker.sv]
// ----------------------------------------------------------------------------
// arpc_checker: port-level checks for the ARP responder and cache
// Watches the top-level ports only and is bound to the top level.
// ----------------------------------------------------------------------------
module arpc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input arpc_pkg::arpc_in_t              in_data,
  input logic                            out_valid,
  input logic                            out_ready,
  input arpc_pkg::arpc_out_t             out_data,
  input logic                            cfg_we,
  input logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [arpc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // A waiting result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // One item at a time: an input transfer is followed by a busy cycle.
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again directly after a transfer");

  // Lookup and message fields never appear in the same result.
  a_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.lookup_hit || out_data.need_request) |->
      !out_data.send_reply && !out_data.table_full_drop &&
      !(out_data.lookup_hit && out_data.need_request))
    else $error("mixed lookup and message result");

  // A miss reports broadcast; no reply means empty reply addresses.
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (!out_data.need_request || out_data.lookup_mac == arpc_pkg::BCAST_MAC) &&
      (out_data.send_reply ||
       (out_data.reply_dst_mac == '0 && out_data.reply_dst_ip == '0)))
    else $error("inconsistent result fields");

endmodule

bind arp_responder_and_cache arpc_checker u_arpc_checker (.*);
